// ===== design/i8mac_pkg.sv =====
package i8mac_pkg;

	// Lane count and the fixed number of per-lane fields in one transaction.
	localparam int LANES = 4;
	localparam int NFIELD = 4;

	// Output queue that holds finished results while the consumer stalls.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// Q0.31 multiplier fraction width and its round-half-up constant.
	localparam int FRAC_BITS = 31;
	localparam logic signed [63:0] ROUND_BIAS = 64'sd1 <<< (FRAC_BITS - 1);

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ACT_OFFSET  = 3'd0,
		REG_WGT_OFFSET  = 3'd1,
		REG_OUT_OFFSET  = 3'd2,
		REG_SCALE_MULT  = 3'd3,
		REG_SCALE_SHIFT = 3'd4,
		REG_CLAMP_LOW   = 3'd5,
		REG_CLAMP_HIGH  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [7:0]  act_value;
		logic               pad;
		logic signed [7:0]  wgt_lane0;
		logic signed [7:0]  wgt_lane1;
		logic signed [7:0]  wgt_lane2;
		logic signed [7:0]  wgt_lane3;
		logic signed [31:0] bias_lane0;
		logic signed [31:0] bias_lane1;
		logic signed [31:0] bias_lane2;
		logic signed [31:0] bias_lane3;
		logic               first_tap;
		logic               last_tap;
	} in_t;

	typedef struct packed {
		logic signed [7:0] out_lane0;
		logic signed [7:0] out_lane1;
		logic signed [7:0] out_lane2;
		logic signed [7:0] out_lane3;
	} out_t;

	typedef struct packed {
		logic signed [15:0] act_offset;
		logic signed [15:0] wgt_offset;
		logic signed [15:0] out_offset;
		logic signed [31:0] scale_mult;
		logic signed [6:0]  scale_shift;
		logic signed [15:0] clamp_low;
		logic signed [15:0] clamp_high;
	} cfg_t;

	// Per-tap control that travels with the lane data.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tap_ctrl_t;

endpackage

// ===== design/int8_conv_mac_requantize_unit.sv =====
// Four-lane int8 convolution MAC with requantize. One tap transaction is
// accepted per clock while in_stall is low; a tap marked last produces one
// result transaction through the lane and requantize stages (two lane stages
// for offsets and the 16x16 product, one for the accumulator, four for the
// requantize tail with its 32x32 multiplier in each lane). Results collect in
// an eight-entry output queue; in_stall rises only when eight results are
// queued or in flight. A result holds its queue slot from its tap to its
// hand-off, so even with a consumer that never stalls, a stream in which
// every tap is marked last still stalls; windows of two or more taps run at
// one tap per cycle. Configuration writes are always ready and take effect
// at once; write only while no transaction is in flight.
module int8_conv_mac_requantize_unit import i8mac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t               cfg_q;
	tap_ctrl_t          tap_ctrl;
	logic               in_fire, out_fire, push;
	logic signed [7:0]  wgt_a [NFIELD];
	logic signed [31:0] bias_a [NFIELD];
	logic signed [7:0]  res_a [NFIELD];
	logic [LANES-1:0]   rq_valid;
	out_t               push_data;
	out_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   fifo_cnt_q, reserved_q;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid && !out_stall;

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.act_offset  <= '0;
			cfg_q.wgt_offset  <= '0;
			cfg_q.out_offset  <= '0;
			cfg_q.scale_mult  <= 32'sh4000_0000;
			cfg_q.scale_shift <= '0;
			cfg_q.clamp_low   <= -16'sd128;
			cfg_q.clamp_high  <= 16'sd127;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACT_OFFSET:  cfg_q.act_offset  <= cfg_data[15:0];
				REG_WGT_OFFSET:  cfg_q.wgt_offset  <= cfg_data[15:0];
				REG_OUT_OFFSET:  cfg_q.out_offset  <= cfg_data[15:0];
				REG_SCALE_MULT:  cfg_q.scale_mult  <= cfg_data;
				REG_SCALE_SHIFT: cfg_q.scale_shift <= cfg_data[6:0];
				REG_CLAMP_LOW:   cfg_q.clamp_low   <= cfg_data[15:0];
				REG_CLAMP_HIGH:  cfg_q.clamp_high  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Per-lane fields of the input transaction as arrays.
	assign wgt_a[0]  = in_data.wgt_lane0;
	assign wgt_a[1]  = in_data.wgt_lane1;
	assign wgt_a[2]  = in_data.wgt_lane2;
	assign wgt_a[3]  = in_data.wgt_lane3;
	assign bias_a[0] = in_data.bias_lane0;
	assign bias_a[1] = in_data.bias_lane1;
	assign bias_a[2] = in_data.bias_lane2;
	assign bias_a[3] = in_data.bias_lane3;

	assign tap_ctrl.valid = in_fire;
	assign tap_ctrl.first = in_data.first_tap;
	assign tap_ctrl.last  = in_data.last_tap;

	// Lanes: MAC front end and requantize tail; missing lanes read as zero.
	for (genvar k = 0; k < NFIELD; k++) begin : g_lane
		if (k < LANES) begin : g_on
			logic signed [31:0] acc;
			logic               acc_done;

			i8mac_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.cfg       (cfg_q),
				.ctrl      (tap_ctrl),
				.act_value (in_data.act_value),
				.pad       (in_data.pad),
				.wgt       (wgt_a[k]),
				.bias      (bias_a[k]),
				.acc       (acc),
				.acc_done  (acc_done)
			);

			i8mac_requant u_rq (
				.clk       (clk),
				.arst_n    (arst_n),
				.cfg       (cfg_q),
				.acc       (acc),
				.start     (acc_done),
				.res       (res_a[k]),
				.res_valid (rq_valid[k])
			);
		end else begin : g_off
			assign res_a[k] = '0;
		end
	end

	// Merge the lane results into one output transaction.
	assign push = &rq_valid;
	assign push_data.out_lane0 = res_a[0];
	assign push_data.out_lane1 = res_a[1];
	assign push_data.out_lane2 = res_a[2];
	assign push_data.out_lane3 = res_a[3];

	// Output queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Queue pointers, occupancy and the count of results reserved in the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			reserved_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(push) - CNT_W'(out_fire);
			reserved_q <= reserved_q + CNT_W'(in_fire && in_data.last_tap)
				- CNT_W'(out_fire);
		end
	end

	assign in_stall  = (reserved_q == CNT_W'(FIFO_DEPTH));
	assign out_valid = (fifo_cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];

	// Checks on the queue and lane bookkeeping.
	a_reserved_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= CNT_W'(FIFO_DEPTH))
		else $error("reserved result count exceeds queue depth");

	a_queue_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= reserved_q)
		else $error("queue holds more results than were reserved");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q != CNT_W'(FIFO_DEPTH)))
		else $error("result pushed into a full queue");

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(rq_valid == '0) || (&rq_valid))
		else $error("lane results are out of step");

endmodule

// ===== design/i8mac_lane.sv =====
module i8mac_lane import i8mac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  tap_ctrl_t          ctrl,
	input  logic signed [7:0]  act_value,
	input  logic               pad,
	input  logic signed [7:0]  wgt,
	input  logic signed [31:0] bias,
	output logic signed [31:0] acc,
	output logic               acc_done
);

	tap_ctrl_t          ctrl_s1, ctrl_s2;
	logic signed [15:0] a16_s1, w16_s1;
	logic signed [31:0] bias_s1, bias_s2;
	logic signed [31:0] prod_s2;
	logic signed [31:0] acc_q;
	logic               done_q;
	logic signed [15:0] a_ext, w_ext;
	logic signed [31:0] prod_c;

	// Offset adds in 16-bit wrap; a padded tap's activation is zeroed before its offset add.
	assign a_ext = pad ? 16'sd0 : 16'(act_value);
	assign w_ext = 16'(wgt);
	assign prod_c = 32'(a16_s1) * 32'(w16_s1);

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			done_q  <= ctrl_s2.valid && ctrl_s2.last;
		end
	end

	// Data pipeline: offset stage, then the 16x16 product.
	always_ff @(posedge clk) begin
		a16_s1  <= a_ext + cfg.act_offset;
		w16_s1  <= w_ext + cfg.wgt_offset;
		bias_s1 <= bias;
		prod_s2 <= prod_c;
		bias_s2 <= bias_s1;
	end

	// Accumulator: the first tap of a window loads the bias before adding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl_s2.valid) begin
			acc_q <= (ctrl_s2.first ? bias_s2 : acc_q) + prod_s2;
		end
	end

	assign acc      = acc_q;
	assign acc_done = done_q;

endmodule

// ===== design/i8mac_requant.sv =====
module i8mac_requant import i8mac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic signed [31:0] acc,
	input  logic               start,
	output logic signed [7:0]  res,
	output logic               res_valid
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] mul_s1;
	logic signed [31:0] m_s2;
	logic signed [31:0] sh_s3;
	logic signed [7:0]  res_s4;
	logic signed [63:0] mul_c, sum_c;
	logic signed [32:0] m33_c;
	logic signed [31:0] m_c;
	logic signed [6:0]  neg_sh;
	logic [4:0]         lamt, ramt;
	logic               rnd;
	logic signed [31:0] v_c;
	logic signed [15:0] v16, o16, lo16;

	// Valid pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Full-width product of the accumulator and the Q0.31 multiplier.
	assign mul_c = 64'(acc) * 64'(cfg.scale_mult);

	// Round half up, drop the fraction, saturate to int32.
	always_comb begin
		sum_c = mul_s1 + ROUND_BIAS;
		m33_c = sum_c[63:FRAC_BITS];
		if (m33_c[32] != m33_c[31]) begin
			m_c = m33_c[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			m_c = m33_c[31:0];
		end
	end

	// Shift paths: left shift wraps its count modulo 32, right shift rounds,
	// and right shifts of 32 or more always give zero.
	always_comb begin
		neg_sh = -cfg.scale_shift;
		lamt   = neg_sh[4:0];
		ramt   = cfg.scale_shift[4:0];
		rnd    = (ramt == 5'd0) ? 1'b0 : m_s2[5'(ramt - 5'd1)];
		if (cfg.scale_shift[6]) begin
			v_c = m_s2 <<< lamt;
		end else if (cfg.scale_shift[5]) begin
			v_c = '0;
		end else begin
			// Keep the sum signed so the right shift stays arithmetic.
			v_c = (m_s2 >>> ramt) + $signed({31'd0, rnd});
		end
	end

	// Saturate to int16, add the output offset, clamp low then high.
	always_comb begin
		if (sh_s3[31:15] != {17{sh_s3[31]}}) begin
			v16 = sh_s3[31] ? 16'sh8000 : 16'sh7fff;
		end else begin
			v16 = sh_s3[15:0];
		end
		o16  = v16 + cfg.out_offset;
		lo16 = (o16 < cfg.clamp_low) ? cfg.clamp_low : o16;
		if (lo16 > cfg.clamp_high) begin
			lo16 = cfg.clamp_high;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mul_c;
		m_s2   <= m_c;
		sh_s3  <= v_c;
		res_s4 <= lo16[7:0];
	end

	assign res       = res_s4;
	assign res_valid = v_s4;

endmodule
